// ===== rtl/core/usart_pkg.sv =====
// Types and constants shared by the asynchronous USART core.
`timescale 1ns / 1ps
package usart_pkg;

   typedef enum logic [2:0] {
      OP_READ_DATA   = 3'd0,
      OP_READ_STATUS = 3'd1,
      OP_WRITE_DATA  = 3'd2,
      OP_WRITE_CTRL  = 3'd3,
      OP_TICK        = 3'd4,
      OP_RX_BYTE     = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_POST,
      ST_TM_END,
      ST_RX_WB,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      PH_FRAME,
      PH_RXP,
      PH_TXC,
      PH_TICK
   } phase_type;

   localparam logic [1:0] CSR_CPU_CLOCK = 2'd0;
   localparam logic [1:0] CSR_BAUD      = 2'd1;
   localparam logic [1:0] CSR_DSR       = 2'd2;

   localparam logic [25:0] CPU_CLOCK_RESET = 26'd3579545;
   localparam logic [16:0] BAUD_RESET      = 17'd9600;
   localparam logic [31:0] FRAME_RESET     = 32'd3728;
   localparam logic [3:0]  FRAME_BITS_RESET = 4'd10;
   localparam logic [7:0]  RX_HOLD_RESET   = 8'hFF;
   localparam logic [31:0] TX_SAT          = 32'h7FFF_FFFF;

   // nearest supported rate; ties go to the lower one
   localparam logic [16:0] BAUD_MID_600  = 17'd450;
   localparam logic [16:0] BAUD_MID_1200 = 17'd900;
   localparam logic [16:0] BAUD_MID_2400 = 17'd1800;
   localparam logic [16:0] BAUD_MID_4800 = 17'd3600;
   localparam logic [16:0] BAUD_MID_9600 = 17'd7200;
   localparam logic [13:0] BAUD_300  = 14'd300;
   localparam logic [13:0] BAUD_600  = 14'd600;
   localparam logic [13:0] BAUD_1200 = 14'd1200;
   localparam logic [13:0] BAUD_2400 = 14'd2400;
   localparam logic [13:0] BAUD_4800 = 14'd4800;
   localparam logic [13:0] BAUD_9600 = 14'd9600;

   localparam int CMD_TX_EN   = 0;
   localparam int CMD_DTR     = 1;
   localparam int CMD_RX_EN   = 2;
   localparam int CMD_ERR_RST = 4;
   localparam int CMD_RTS     = 5;
   localparam int CMD_IR      = 6;
   localparam int MODE_PARITY = 4;
   localparam int MODE_STOP2  = 7;

endpackage

// ===== rtl/core/usart_async_core.sv =====
// Asynchronous-mode USART core: bus ops, frame timing and receive FIFO.
`timescale 1ns / 1ps
// Usage:
//   req channel carries one operation per item: tuser = op, tdata = data byte
//   and the tick cycle count. rsp channel returns exactly one item per request.
//   csr port writes cpu clock, requested baud and DSR level at any idle time.
// Sequencing:
//   Reads, data writes, command words and received bytes: no multiply or divide.
//   Tick with receive active: a 32-step divide of the cycle
//   count by the frame length, then one FIFO memory read.
//   Mode word or a clock/baud write: a 1-step multiply and a 32-step divide
//   for the frame length; if it changes, up to two more multiply and 64-step
//   divide passes rescale pending progress.
//   All of this runs on one shared multiplier and one restoring divider, so
//   req_tready is low until the item is done.
// Reset: synchronous; counters, FIFO pointers and flags clear, but tx_empty, DSR
//   and mode-word wait set; frame length returns to the reset clock/baud value.
// Stall: a finished result waits in the rsp register; the next request is
//   accepted meanwhile and holds in its last step until the register frees.
module usart_async_core #(
   parameter int RX_FIFO_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], cycles[39:8]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // read_value[7:0], tx_valid[8], tx_byte[16:9],
                                    // dtr_out[17], rts_out[18], rx_dropped[19]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [25:0] csr_wdata
);
   import usart_pkg::*;

   localparam int AW = $clog2(RX_FIFO_DEPTH);
   localparam int CW = $clog2(RX_FIFO_DEPTH + 1);
   localparam int HW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C  = CW'(RX_FIFO_DEPTH);
   localparam logic [HW-1:0] DEPTH_HW = HW'(RX_FIFO_DEPTH);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic from_cfg_ff, from_cfg_in, cfg_pend_ff, cfg_pend_in;
   logic [25:0] cpu_ff, cpu_in;
   logic [16:0] baud_ff, baud_in;
   logic dsr_ff, dsr_in, expect_mode_ff, expect_mode_in;
   logic [3:0] frame_bits_ff, frame_bits_in;
   logic tx_en_ff, tx_en_in, rx_en_ff, rx_en_in, dtr_ff, dtr_in, rts_ff, rts_in;
   logic overrun_ff, overrun_in, tx_ready_ff, tx_ready_in, tx_empty_ff, tx_empty_in;
   logic tx_busy_ff, tx_busy_in, rx_ready_ff, rx_ready_in;
   logic [7:0] tx_hold_ff, tx_hold_in, rx_hold_ff, rx_hold_in;
   logic [31:0] tx_cd_ff, tx_cd_in, frame_ff, frame_in, new_frame_ff, new_frame_in;
   logic [31:0] part_ff, part_in, cyc_ff, cyc_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0] prod_ff, prod_in, div_num_ff, div_num_in;
   logic [31:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [6:0] div_cnt_ff, div_cnt_in;
   logic [7:0] res_rd_ff, res_rd_in, res_txb_ff, res_txb_in;
   logic res_txv_ff, res_txv_in, res_drop_ff, res_drop_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic [7:0] mem [RX_FIFO_DEPTH];
   logic [7:0] mem_q_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   logic [13:0] ebaud;
   logic [31:0] mul_a, mul_b;
   logic [32:0] div_trial, div_diff;
   logic [7:0] v_byte;
   logic [31:0] cycles;
   logic [31:0] q_lo, nw;
   logic [64:0] qc;
   logic [32:0] psum, total;
   logic extra;
   logic [31:0] pnew;
   logic [CW-1:0] take, count_new;
   logic [HW-1:0] head_sum, last_sum, pos_sum;

   assign v_byte = req_tdata[7:0];
   assign cycles = req_tdata[39:8];

   always_comb begin
      if (baud_ff <= BAUD_MID_600) ebaud = BAUD_300;
      else if (baud_ff <= BAUD_MID_1200) ebaud = BAUD_600;
      else if (baud_ff <= BAUD_MID_2400) ebaud = BAUD_1200;
      else if (baud_ff <= BAUD_MID_4800) ebaud = BAUD_2400;
      else if (baud_ff <= BAUD_MID_9600) ebaud = BAUD_4800;
      else ebaud = BAUD_9600;
   end

   assign div_trial = {div_rem_ff, div_num_ff[63]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};

   assign q_lo  = div_num_ff[31:0];
   assign nw    = (q_lo == 32'd0) ? 32'd1 : q_lo;
   assign qc    = {1'b0, div_num_ff} + {64'd0, (div_rem_ff != 32'd0)};
   assign psum  = {1'b0, div_rem_ff} + {1'b0, part_ff};
   assign extra = psum >= {1'b0, frame_ff};
   assign pnew  = extra ? 32'(psum - {1'b0, frame_ff}) : psum[31:0];
   assign total = {1'b0, q_lo} + {32'd0, extra};
   assign take  = (total >= 33'(count_ff)) ? count_ff : total[CW-1:0];
   assign count_new = count_ff - take;
   assign head_sum = HW'(head_ff) + HW'(take);
   assign last_sum = head_sum - HW'(1);
   assign pos_sum  = HW'(head_ff) + HW'(count_ff);

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; from_cfg_in = from_cfg_ff;
      cfg_pend_in = cfg_pend_ff; cpu_in = cpu_ff; baud_in = baud_ff; dsr_in = dsr_ff;
      expect_mode_in = expect_mode_ff; frame_bits_in = frame_bits_ff;
      tx_en_in = tx_en_ff; rx_en_in = rx_en_ff; dtr_in = dtr_ff; rts_in = rts_ff;
      overrun_in = overrun_ff; tx_ready_in = tx_ready_ff; tx_empty_in = tx_empty_ff;
      tx_busy_in = tx_busy_ff; rx_ready_in = rx_ready_ff; tx_hold_in = tx_hold_ff;
      rx_hold_in = rx_hold_ff; tx_cd_in = tx_cd_ff; frame_in = frame_ff;
      new_frame_in = new_frame_ff; part_in = part_ff; cyc_in = cyc_ff;
      head_in = head_ff; count_in = count_ff; prod_in = prod_ff;
      res_rd_in = res_rd_ff; res_txb_in = res_txb_ff; res_txv_in = res_txv_ff;
      res_drop_in = res_drop_ff; rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      mul_a = 32'd0; mul_b = 32'd0;
      wr_en = 1'b0;
      wr_addr = (pos_sum >= DEPTH_HW) ? AW'(pos_sum - DEPTH_HW) : AW'(pos_sum);
      rd_addr = (last_sum >= DEPTH_HW) ? AW'(last_sum - DEPTH_HW) : AW'(last_sum);
      req_tready = (state_ff == ST_IDLE) && !cfg_pend_ff;

      div_num_in = div_num_ff; div_rem_in = div_rem_ff; div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      if (div_cnt_ff != 7'd0) begin
         div_cnt_in = div_cnt_ff - 7'd1;
         if (!div_diff[32]) begin
            div_rem_in = div_diff[31:0];
            div_num_in = {div_num_ff[62:0], 1'b1};
         end else begin
            div_rem_in = div_trial[31:0];
            div_num_in = {div_num_ff[62:0], 1'b0};
         end
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (phase_ff)
         PH_FRAME: begin
            mul_a = {6'd0, cpu_ff};
            mul_b = {28'd0, frame_bits_ff};
         end
         PH_RXP: begin
            mul_a = part_ff;
            mul_b = new_frame_ff;
         end
         PH_TXC: begin
            mul_a = tx_cd_ff;
            mul_b = new_frame_ff;
         end
         default: ;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (cfg_pend_ff) begin
               cfg_pend_in = 1'b0;
               from_cfg_in = 1'b1;
               phase_in = PH_FRAME;
               state_in = ST_MUL;
            end else if (req_tvalid) begin
               res_rd_in = 8'd0; res_txv_in = 1'b0; res_txb_in = 8'd0;
               res_drop_in = 1'b0; from_cfg_in = 1'b0;
               state_in = ST_FIN;
               case (op_type'(req_tuser))
                  OP_READ_DATA: begin
                     res_rd_in = rx_hold_ff;
                     rx_ready_in = 1'b0;
                  end
                  OP_READ_STATUS: begin
                     res_rd_in = {dsr_ff, 2'b00, overrun_ff, 1'b0, tx_empty_ff,
                                  rx_ready_ff, tx_ready_ff};
                  end
                  OP_WRITE_DATA: begin
                     if (tx_en_ff) begin
                        tx_hold_in = v_byte; tx_busy_in = 1'b1;
                        tx_ready_in = 1'b0; tx_empty_in = 1'b0;
                        tx_cd_in = frame_ff;
                     end
                  end
                  OP_WRITE_CTRL: begin
                     if (!expect_mode_ff && v_byte[CMD_IR]) begin
                        expect_mode_in = 1'b1;
                        tx_en_in = 1'b0; rx_en_in = 1'b0;
                        tx_ready_in = 1'b0; tx_empty_in = 1'b1;
                        tx_busy_in = 1'b0; tx_cd_in = 32'd0;
                        part_in = 32'd0; rx_ready_in = 1'b0; overrun_in = 1'b0;
                     end else if (expect_mode_ff) begin
                        frame_bits_in = 4'd6 + {2'b00, v_byte[3:2]} +
                                        {3'b000, v_byte[MODE_PARITY]} +
                                        (v_byte[MODE_STOP2] ? 4'd2 : 4'd1);
                        expect_mode_in = 1'b0;
                        phase_in = PH_FRAME;
                        state_in = ST_MUL;
                     end else begin
                        tx_en_in = v_byte[CMD_TX_EN];
                        dtr_in = v_byte[CMD_DTR];
                        rx_en_in = v_byte[CMD_RX_EN];
                        if (v_byte[CMD_ERR_RST]) overrun_in = 1'b0;
                        rts_in = v_byte[CMD_RTS];
                        if (v_byte[CMD_TX_EN] && !tx_busy_ff && tx_cd_ff == 32'd0)
                           tx_ready_in = 1'b1;
                        if (!v_byte[CMD_TX_EN]) tx_ready_in = 1'b0;
                     end
                  end
                  OP_TICK: begin
                     if (tx_busy_ff && tx_cd_ff != 32'd0) begin
                        if (cycles >= tx_cd_ff) begin
                           tx_cd_in = 32'd0;
                           res_txv_in = 1'b1; res_txb_in = tx_hold_ff;
                           tx_busy_in = 1'b0; tx_ready_in = tx_en_ff;
                           tx_empty_in = 1'b1;
                        end else begin
                           tx_cd_in = tx_cd_ff - cycles;
                        end
                     end
                     cyc_in = cycles;
                     if (rx_en_ff && count_ff != '0) begin
                        phase_in = PH_TICK;
                        state_in = ST_LOAD;
                     end else begin
                        part_in = 32'd0;
                     end
                  end
                  OP_RX_BYTE: begin
                     if (count_ff < DEPTH_C) begin
                        wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_drop_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            prod_in = mul_a * mul_b;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            div_rem_in = 32'd0;
            case (phase_ff)
               PH_FRAME: begin
                  div_num_in = {prod_ff[31:0], 32'd0};
                  div_den_in = {18'd0, ebaud};
                  div_cnt_in = 7'd32;
               end
               PH_TICK: begin
                  div_num_in = {cyc_ff, 32'd0};
                  div_den_in = frame_ff;
                  div_cnt_in = 7'd32;
               end
               default: begin
                  div_num_in = prod_ff;
                  div_den_in = frame_ff;
                  div_cnt_in = 7'd64;
               end
            endcase
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == 7'd0) state_in = ST_POST;
         end
         ST_POST: begin
            case (phase_ff)
               PH_FRAME: begin
                  new_frame_in = nw;
                  if (nw != frame_ff) begin
                     phase_in = PH_RXP;
                     state_in = ST_MUL;
                  end else begin
                     state_in = ST_TM_END;
                  end
               end
               PH_RXP: begin
                  part_in = q_lo;
                  if (tx_busy_ff && tx_cd_ff != 32'd0) begin
                     phase_in = PH_TXC;
                     state_in = ST_MUL;
                  end else begin
                     state_in = ST_TM_END;
                  end
               end
               PH_TXC: begin
                  tx_cd_in = (qc > {33'd0, TX_SAT}) ? TX_SAT : qc[31:0];
                  state_in = ST_TM_END;
               end
               default: begin
                  part_in = (count_new != '0) ? pnew : 32'd0;
                  if (take != '0) begin
                     overrun_in = overrun_ff | rx_ready_ff | (take > CW'(1));
                     rx_ready_in = 1'b1;
                     head_in = (head_sum >= DEPTH_HW) ? AW'(head_sum - DEPTH_HW)
                                                      : AW'(head_sum);
                     count_in = count_new;
                     state_in = ST_RX_WB;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
            endcase
         end
         ST_TM_END: begin
            frame_in = new_frame_ff;
            state_in = from_cfg_ff ? ST_IDLE : ST_FIN;
         end
         ST_RX_WB: begin
            rx_hold_in = mem_q_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'd0, res_drop_ff, rts_ff, dtr_ff, res_txb_ff, res_txv_ff,
                              res_rd_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_addr)
            CSR_CPU_CLOCK: begin
               cpu_in = csr_wdata;
               cfg_pend_in = 1'b1;
            end
            CSR_BAUD: begin
               baud_in = csr_wdata[16:0];
               cfg_pend_in = 1'b1;
            end
            CSR_DSR: dsr_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; phase_ff <= PH_FRAME; from_cfg_ff <= 1'b0;
         cfg_pend_ff <= 1'b0; cpu_ff <= CPU_CLOCK_RESET; baud_ff <= BAUD_RESET;
         dsr_ff <= 1'b1; expect_mode_ff <= 1'b1; frame_bits_ff <= FRAME_BITS_RESET;
         tx_en_ff <= 1'b0; rx_en_ff <= 1'b0; dtr_ff <= 1'b0; rts_ff <= 1'b0;
         overrun_ff <= 1'b0; tx_ready_ff <= 1'b0; tx_empty_ff <= 1'b1;
         tx_busy_ff <= 1'b0; rx_ready_ff <= 1'b0; tx_hold_ff <= 8'd0;
         rx_hold_ff <= RX_HOLD_RESET; tx_cd_ff <= 32'd0; frame_ff <= FRAME_RESET;
         part_ff <= 32'd0; head_ff <= '0; count_ff <= '0; div_cnt_ff <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; from_cfg_ff <= from_cfg_in;
         cfg_pend_ff <= cfg_pend_in; cpu_ff <= cpu_in; baud_ff <= baud_in;
         dsr_ff <= dsr_in; expect_mode_ff <= expect_mode_in;
         frame_bits_ff <= frame_bits_in; tx_en_ff <= tx_en_in; rx_en_ff <= rx_en_in;
         dtr_ff <= dtr_in; rts_ff <= rts_in; overrun_ff <= overrun_in;
         tx_ready_ff <= tx_ready_in; tx_empty_ff <= tx_empty_in;
         tx_busy_ff <= tx_busy_in; rx_ready_ff <= rx_ready_in; tx_hold_ff <= tx_hold_in;
         rx_hold_ff <= rx_hold_in; tx_cd_ff <= tx_cd_in; frame_ff <= frame_in;
         part_ff <= part_in; head_ff <= head_in; count_ff <= count_in;
         div_cnt_ff <= div_cnt_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_frame_ff <= new_frame_in; cyc_ff <= cyc_in; prod_ff <= prod_in;
      div_num_ff <= div_num_in; div_rem_ff <= div_rem_in; div_den_ff <= div_den_in;
      res_rd_ff <= res_rd_in; res_txb_ff <= res_txb_in; res_txv_ff <= res_txv_in;
      res_drop_ff <= res_drop_in; rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= v_byte;
      mem_q_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("rx fifo count beyond depth");

   a_frame_nonzero: assert property (@(posedge clock) disable iff (reset)
      frame_ff != 32'd0) else $error("frame length is zero");

   a_tx_busy_flags: assert property (@(posedge clock) disable iff (reset)
      tx_busy_ff |-> (!tx_ready_ff && !tx_empty_ff))
      else $error("tx flags set while frame in flight");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff == 7'd0) |=> state_ff == ST_POST)
      else $error("divider result not consumed");

   a_fin_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("result not issued");

endmodule
